FILE: design/uart_8n2_transceiver_assert.svh
// Assertion macros for the serial transceiver.
`ifndef UART_8N2_TRANSCEIVER_ASSERT_SVH
`define UART_8N2_TRANSCEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define U8T_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8t: implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define U8T_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8t: next-cycle check failed");

`endif

FILE: design/u8t_pkg.sv
// Shared types and constants of the serial transceiver.
`default_nettype none
package u8t_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERIOD_W   = 16;
  localparam int RX_TICKS_W = PERIOD_W + 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd104;

  localparam int IN_TDATA_W   = 16;
  localparam int OUT_FIELDS_W = 3 + BYTE_W;
  localparam int OUT_TDATA_W  = 16;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_res_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_res_t;

endpackage
`default_nettype wire

FILE: design/u8t_tx.sv
// Transmitter: frame sequencer advanced once per tick.
`default_nettype none
module u8t_tx #(
  parameter int DATA_BITS = 8,
  parameter int STOP_BITS = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [u8t_pkg::PERIOD_W-1:0]   period,
  input  logic                           send_valid,
  input  logic [u8t_pkg::BYTE_W-1:0]     send_byte,
  output u8t_pkg::tx_res_t               res
);
  import u8t_pkg::*;

  localparam int FRAME_BITS = 2 + DATA_BITS + STOP_BITS;
  localparam int PH_W       = $clog2(FRAME_BITS + 1);

  localparam logic [PH_W-1:0] PH_IDLE       = PH_W'(0);
  localparam logic [PH_W-1:0] PH_MARK       = PH_W'(1);
  localparam logic [PH_W-1:0] PH_START      = PH_W'(2);
  localparam logic [PH_W-1:0] PH_FIRST_DATA = PH_W'(3);
  localparam logic [PH_W-1:0] PH_LAST_DATA  = PH_W'(2 + DATA_BITS);
  localparam logic [PH_W-1:0] PH_LAST       = PH_W'(FRAME_BITS);

  logic [PH_W-1:0]     phase_r, phase_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic [PERIOD_W-1:0] ticks_r, ticks_nxt;

  logic [PH_W-1:0]     ph_a;
  logic [BYTE_W-1:0]   sh_a;
  logic [PERIOD_W-1:0] tk_a;
  logic [PERIOD_W-1:0] tk_inc;

  always_comb begin
    ph_a = phase_r;
    sh_a = shift_r;
    tk_a = ticks_r;
    // a request taken while idle opens the frame on this tick
    if (phase_r == PH_IDLE && send_valid) begin
      ph_a = PH_MARK;
      sh_a = send_byte;
      tk_a = '0;
    end
    tk_inc    = tk_a + 1'b1;
    phase_nxt = ph_a;
    shift_nxt = sh_a;
    ticks_nxt = tk_a;
    res.line  = 1'b1;
    res.busy  = 1'b0;
    if (ph_a != PH_IDLE) begin
      res.busy = 1'b1;
      if (ph_a == PH_MARK) begin
        res.line = 1'b1;
      end else if (ph_a == PH_START) begin
        res.line = 1'b0;
      end else if (ph_a <= PH_LAST_DATA) begin
        res.line = sh_a[0];
      end else begin
        res.line = 1'b1;
      end
      if (tk_inc >= period) begin
        ticks_nxt = '0;
        if (ph_a >= PH_FIRST_DATA && ph_a <= PH_LAST_DATA) begin
          shift_nxt = sh_a >> 1;
        end
        phase_nxt = (ph_a == PH_LAST) ? PH_IDLE : ph_a + 1'b1;
      end else begin
        ticks_nxt = tk_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= '0;
      ticks_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      ticks_r <= ticks_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/u8t_rx.sv
// Receiver: start hunt, mid-bit sampling and word report, once per tick.
`default_nettype none
module u8t_rx #(
  parameter int DATA_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [u8t_pkg::PERIOD_W-1:0]   period,
  input  logic                           line,
  output u8t_pkg::rx_res_t               res
);
  import u8t_pkg::*;

  localparam int PH_W = $clog2(DATA_BITS + 2);

  localparam logic [PH_W-1:0] PH_HUNT      = PH_W'(0);
  localparam logic [PH_W-1:0] PH_FIRST     = PH_W'(1);
  localparam logic [PH_W-1:0] PH_LAST_DATA = PH_W'(DATA_BITS);

  logic [PH_W-1:0]       phase_r, phase_nxt;
  logic [DATA_BITS-1:0]  shift_r, shift_nxt;
  logic [RX_TICKS_W-1:0] ticks_r, ticks_nxt;

  logic [RX_TICKS_W-1:0]       tk_dec;
  logic [RX_TICKS_W-1:0]       start_wait;
  logic [DATA_BITS+BYTE_W-1:0] word_ext;

  assign start_wait = {1'b0, period} + {2'b00, period[PERIOD_W-1:1]};
  assign word_ext   = {{BYTE_W{1'b0}}, shift_r};

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    ticks_nxt = ticks_r;
    res.valid = 1'b0;
    res.data  = '0;
    tk_dec    = (ticks_r != '0) ? ticks_r - 1'b1 : ticks_r;
    if (phase_r == PH_HUNT) begin
      // wait one and a half bits to land mid-way into the first data bit
      if (!line) begin
        phase_nxt = PH_FIRST;
        shift_nxt = '0;
        ticks_nxt = start_wait;
      end
    end else if (tk_dec == '0) begin
      if (phase_r <= PH_LAST_DATA) begin
        shift_nxt = {line, shift_r[DATA_BITS-1:1]};
        ticks_nxt = {1'b0, period};
        phase_nxt = phase_r + 1'b1;
      end else begin
        // stop bit goes unchecked; report and hunt from the next tick
        res.valid = 1'b1;
        res.data  = word_ext[BYTE_W-1:0];
        ticks_nxt = tk_dec;
        phase_nxt = PH_HUNT;
      end
    end else begin
      ticks_nxt = tk_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      shift_r <= '0;
      ticks_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      ticks_r <= ticks_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/uart_8n2_transceiver.sv
// Top level of the tick-driven serial transceiver.
`default_nettype none
`include "uart_8n2_transceiver_assert.svh"
// Each request on the in_ stream is one timing tick of the serial line and
// yields exactly one result on the out_ stream. A request can be taken on
// every clock cycle unless the pipeline stalls; its result passes through the
// input register and then the result register. Both stages hold only while a
// result waits in the result register and out_tready is low. The transmitter
// frames a byte as one idle-high bit, a start bit,
// DATA_BITS data bits LSB first and STOP_BITS stop bits, each bit_period ticks
// long; a send request while busy is dropped. The receiver samples 1.5 bit
// periods after a falling line and then once per bit, reporting the word one
// bit later. bit_period (0 acts as 1) is written on the cfg_ channel; the user
// must do so only while no request is in flight, which the block does not enforce.
module uart_8n2_transceiver #(
  parameter int DATA_BITS = 8,
  parameter int STOP_BITS = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] rx_line, [1] send_valid, [9:2] send_byte, rest zero
  input  logic [u8t_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] tx_line, [1] tx_busy, [2] rx_valid, [10:3] rx_byte, rest zero
  output logic [u8t_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [u8t_pkg::PERIOD_W-1:0]      cfg_data
);
  import u8t_pkg::*;

  logic [PERIOD_W-1:0] bit_period_r;
  logic [PERIOD_W-1:0] period_eff;

  logic                s1_valid_r;
  logic                s1_line_r;
  logic                s1_send_r;
  logic [BYTE_W-1:0]   s1_byte_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic     out_free;
  logic     step;
  tx_res_t  tx_res;
  rx_res_t  rx_res;

  assign cfg_ready  = 1'b1;
  assign period_eff = (bit_period_r == '0) ? PERIOD_W'(1) : bit_period_r;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      bit_period_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_line_r <= in_tdata[0];
      s1_send_r <= in_tdata[1];
      s1_byte_r <= in_tdata[2 +: BYTE_W];
    end
  end

  u8t_tx #(
    .DATA_BITS (DATA_BITS),
    .STOP_BITS (STOP_BITS)
  ) u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .period     (period_eff),
    .send_valid (s1_send_r),
    .send_byte  (s1_byte_r),
    .res        (tx_res)
  );

  u8t_rx #(
    .DATA_BITS (DATA_BITS)
  ) u_rx (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .period (period_eff),
    .line   (s1_line_r),
    .res    (rx_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_tdata_r <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                      rx_res.data, rx_res.valid, tx_res.busy, tx_res.line};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  `U8T_ASSERT_NXT(a_step_gives_result, step, out_valid_r)
  `U8T_ASSERT_IMP(a_full_pipe_accept_moves, in_tvalid && in_tready && s1_valid_r, step)
  `U8T_ASSERT_IMP(a_idle_tx_high, out_tvalid && !out_tdata[1], out_tdata[0])
  `U8T_ASSERT_IMP(a_no_word_zero, out_tvalid && !out_tdata[2], out_tdata[10:3] == '0)

endmodule
`default_nettype wire
